### hw/rtl/als_pkg.sv
package als_pkg;

    localparam int MAX_WORKERS = 16;
    localparam int INDEX_BITS  = 16;
    localparam int WID_W       = 4;
    localparam int NW_W        = 5;
    localparam int DVD_W       = INDEX_BITS + 1;
    localparam int DIV_CNT_W   = 5;
    localparam int PREM_W      = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;
    localparam int GRANT_W     = 3;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DVD_W - 1);

    localparam logic REQ_BEGIN = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ITER  = 1'b1;

    localparam logic [NW_W-1:0]       NUM_WORKERS_RST = NW_W'(4);
    localparam logic [INDEX_BITS-1:0] TOTAL_ITER_RST  = INDEX_BITS'(1024);

    typedef enum logic [GRANT_W-1:0] {
        GRANT_LOCAL  = 3'd0,
        GRANT_STOLEN = 3'd1,
        GRANT_DONE   = 3'd2,
        GRANT_BEGUN  = 3'd3,
        GRANT_BADID  = 3'd4
    } grant_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_DIV_TAKE,
        ST_TAKE,
        ST_DIV_BEGIN,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_WID,
        ADDR_INC,
        ADDR_BEST
    } addr_op_t;

    typedef enum logic {
        DIV_SRC_TOTAL,
        DIV_SRC_REM
    } div_src_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        div_src_t div_src;
        logic     div_step;
        addr_op_t addr_op;
        logic     scan_clear;
        logic     scan_step;
        logic     sweep_write;
        logic     take_write;
        logic     load_out;
        grant_t   grant;
    } cmd_t;

    typedef struct packed {
        logic is_begin;
        logic bad_id;
        logic rem_zero;
        logic best_found;
        logic addr_last;
        logic div_last;
    } stat_t;

endpackage

### hw/rtl/als_ctrl.sv
module als_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  als_pkg::stat_t stat,
    output als_pkg::cmd_t  cmd
);

    als_pkg::state_t state_reg, state_next;
    als_pkg::grant_t grant_reg, grant_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= als_pkg::ST_IDLE;
            grant_reg     <= als_pkg::GRANT_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grant_reg     <= grant_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        grant_next     = grant_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_src    = als_pkg::DIV_SRC_TOTAL;
        cmd.addr_op    = als_pkg::ADDR_HOLD;
        cmd.grant      = grant_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            als_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = als_pkg::ST_DECODE;
                end
            end
            als_pkg::ST_DECODE:
            begin
                if (stat.is_begin)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = als_pkg::DIV_SRC_TOTAL;
                    cmd.addr_op   = als_pkg::ADDR_ZERO;
                    grant_next    = als_pkg::GRANT_BEGUN;
                    state_next    = als_pkg::ST_DIV_BEGIN;
                end
                else if (stat.bad_id)
                begin
                    grant_next = als_pkg::GRANT_BADID;
                    state_next = als_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.addr_op = als_pkg::ADDR_WID;
                    state_next  = als_pkg::ST_CHECK;
                end
            end
            als_pkg::ST_CHECK:
            begin
                if (!stat.rem_zero)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = als_pkg::DIV_SRC_REM;
                    grant_next    = als_pkg::GRANT_LOCAL;
                    state_next    = als_pkg::ST_DIV_TAKE;
                end
                else
                begin
                    cmd.addr_op    = als_pkg::ADDR_ZERO;
                    cmd.scan_clear = 1'b1;
                    state_next     = als_pkg::ST_SCAN;
                end
            end
            als_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = als_pkg::ST_SCAN_END;
                end
                else
                begin
                    cmd.addr_op = als_pkg::ADDR_INC;
                end
            end
            als_pkg::ST_SCAN_END:
            begin
                if (stat.best_found)
                begin
                    cmd.addr_op = als_pkg::ADDR_BEST;
                    state_next  = als_pkg::ST_PICK;
                end
                else
                begin
                    grant_next = als_pkg::GRANT_DONE;
                    state_next = als_pkg::ST_FINISH;
                end
            end
            als_pkg::ST_PICK:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = als_pkg::DIV_SRC_REM;
                grant_next    = als_pkg::GRANT_STOLEN;
                state_next    = als_pkg::ST_DIV_TAKE;
            end
            als_pkg::ST_DIV_TAKE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = als_pkg::ST_TAKE;
                end
            end
            als_pkg::ST_TAKE:
            begin
                cmd.take_write = 1'b1;
                state_next     = als_pkg::ST_FINISH;
            end
            als_pkg::ST_DIV_BEGIN:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = als_pkg::ST_SWEEP;
                end
            end
            als_pkg::ST_SWEEP:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = als_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.addr_op = als_pkg::ADDR_INC;
                end
            end
            als_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = als_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = als_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/als_dp.sv
module als_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [als_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [als_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_req_type,
    input  logic [als_pkg::WID_W-1:0]           in_worker_id,
    input  als_pkg::cmd_t                       cmd,
    output als_pkg::stat_t                      stat,
    output logic [als_pkg::INDEX_BITS-1:0]      out_chunk_start,
    output logic [als_pkg::INDEX_BITS-1:0]      out_chunk_end,
    output logic [als_pkg::GRANT_W-1:0]         out_grant_status,
    output logic [als_pkg::WID_W-1:0]           out_victim_id
);

    localparam int IW = als_pkg::INDEX_BITS;
    localparam int WW = als_pkg::WID_W;
    localparam int NW = als_pkg::NW_W;

    // Configuration registers.
    logic [NW-1:0] num_workers_reg;
    logic [IW-1:0] total_iter_reg;

    // Block table, one entry per worker.
    logic [IW-1:0] block_next_reg [als_pkg::MAX_WORKERS];
    logic [IW-1:0] block_end_reg  [als_pkg::MAX_WORKERS];

    logic                            req_reg;
    logic [WW-1:0]                   wid_reg;
    logic [WW-1:0]                   addr_reg, addr_next;
    logic [IW-1:0]                   acc_reg, acc_next;
    logic [WW-1:0]                   best_reg, best_next;
    logic [IW-1:0]                   best_rem_reg, best_rem_next;
    logic [als_pkg::DVD_W-1:0]       dvd_reg, dvd_next;
    logic [als_pkg::PREM_W-1:0]      prem_reg, prem_next;
    logic [als_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]                   res_lo_reg, res_hi_reg;
    logic [WW-1:0]                   res_victim_reg;
    logic [IW-1:0]                   out_start_reg, out_end_reg;
    logic [WW-1:0]                   out_victim_reg;
    als_pkg::grant_t                 out_grant_reg;

    logic [NW-1:0]                   nw;
    logic [IW-1:0]                   rd_next, rd_end, rd_rem;
    logic [als_pkg::DVD_W-1:0]       div_base;
    logic [NW-1:0]                   trial;
    logic                            trial_ge;
    logic [IW-1:0]                   quot;
    logic                            in_range;
    logic [IW:0]                     sweep_sum;
    logic [IW-1:0]                   sweep_end;
    logic [IW-1:0]                   take_hi;
    logic                            wr_en;
    logic [IW-1:0]                   wr_lo_next, wr_hi_next;

    // Worker count in use: zero acts as one, anything above the table size saturates.
    always_comb
    begin
        if (num_workers_reg == '0)
        begin
            nw = NW'(1);
        end
        else if (num_workers_reg > NW'(als_pkg::MAX_WORKERS))
        begin
            nw = NW'(als_pkg::MAX_WORKERS);
        end
        else
        begin
            nw = num_workers_reg;
        end
    end

    assign rd_next = block_next_reg[addr_reg];
    assign rd_end  = block_end_reg[addr_reg];
    assign rd_rem  = (rd_end > rd_next) ? (rd_end - rd_next) : '0;

    // Restoring divider, one quotient bit per step; quotient shifts into dvd_reg.
    assign div_base = (cmd.div_src == als_pkg::DIV_SRC_TOTAL) ?
                      {1'b0, total_iter_reg} : {1'b0, rd_rem};
    assign trial    = {prem_reg, dvd_reg[als_pkg::DVD_W-1]};
    assign trial_ge = (trial >= nw);
    assign quot     = dvd_reg[IW-1:0];

    assign in_range  = ({1'b0, addr_reg} < nw);
    assign sweep_sum = {1'b0, acc_reg} + {1'b0, quot};
    assign sweep_end = (sweep_sum > {1'b0, total_iter_reg}) ? total_iter_reg : sweep_sum[IW-1:0];
    assign take_hi   = rd_next + quot;

    always_comb
    begin
        dvd_next      = dvd_reg;
        prem_next     = prem_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        best_rem_next = best_rem_reg;
        addr_next     = addr_reg;
        wr_en         = 1'b0;
        wr_lo_next    = rd_next;
        wr_hi_next    = rd_end;

        if (cmd.div_start)
        begin
            dvd_next  = div_base + als_pkg::DVD_W'(nw) - als_pkg::DVD_W'(1);
            prem_next = '0;
            cnt_next  = als_pkg::DIV_LAST_STEP;
            acc_next  = '0;
        end
        else if (cmd.div_step)
        begin
            dvd_next  = {dvd_reg[als_pkg::DVD_W-2:0], trial_ge};
            prem_next = trial_ge ? als_pkg::PREM_W'(trial - nw) : trial[als_pkg::PREM_W-1:0];
            cnt_next  = cnt_reg - als_pkg::DIV_CNT_W'(1);
        end

        if (cmd.scan_clear)
        begin
            best_next     = '0;
            best_rem_next = '0;
        end
        else if (cmd.scan_step && (rd_rem > best_rem_reg))
        begin
            best_next     = addr_reg;
            best_rem_next = rd_rem;
        end

        if (cmd.sweep_write)
        begin
            wr_en      = 1'b1;
            wr_lo_next = in_range ? acc_reg : '0;
            wr_hi_next = in_range ? sweep_end : '0;
            acc_next   = sweep_end;
        end
        else if (cmd.take_write)
        begin
            wr_en      = 1'b1;
            wr_lo_next = take_hi;
            wr_hi_next = rd_end;
        end

        unique case (cmd.addr_op)
            als_pkg::ADDR_HOLD: addr_next = addr_reg;
            als_pkg::ADDR_ZERO: addr_next = '0;
            als_pkg::ADDR_WID:  addr_next = wid_reg;
            als_pkg::ADDR_INC:  addr_next = addr_reg + WW'(1);
            als_pkg::ADDR_BEST: addr_next = best_reg;
            default:            addr_next = addr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_workers_reg <= als_pkg::NUM_WORKERS_RST;
            total_iter_reg  <= als_pkg::TOTAL_ITER_RST;
            for (int i = 0; i < als_pkg::MAX_WORKERS; i++)
            begin
                block_next_reg[i] <= '0;
                block_end_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    als_pkg::CFG_NUM_WORKERS: num_workers_reg <= cfg_data[NW-1:0];
                    als_pkg::CFG_TOTAL_ITER:  total_iter_reg  <= cfg_data[IW-1:0];
                    default:                  num_workers_reg <= num_workers_reg;
                endcase
            end
            if (wr_en)
            begin
                block_next_reg[addr_reg] <= wr_lo_next;
                block_end_reg[addr_reg]  <= wr_hi_next;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        best_rem_reg <= best_rem_next;
        dvd_reg      <= dvd_next;
        prem_reg     <= prem_next;
        cnt_reg      <= cnt_next;
        if (cmd.capture)
        begin
            req_reg        <= in_req_type;
            wid_reg        <= in_worker_id;
            res_lo_reg     <= '0;
            res_hi_reg     <= '0;
            res_victim_reg <= '0;
        end
        else if (cmd.take_write)
        begin
            res_lo_reg     <= rd_next;
            res_hi_reg     <= take_hi;
            res_victim_reg <= addr_reg;
        end
        if (cmd.load_out)
        begin
            out_start_reg  <= res_lo_reg;
            out_end_reg    <= res_hi_reg;
            out_victim_reg <= res_victim_reg;
            out_grant_reg  <= cmd.grant;
        end
    end

    assign stat.is_begin   = (req_reg == als_pkg::REQ_BEGIN);
    assign stat.bad_id     = ({1'b0, wid_reg} >= nw);
    assign stat.rem_zero   = (rd_rem == '0);
    assign stat.best_found = (best_rem_reg != '0);
    assign stat.addr_last  = (addr_reg == WW'(als_pkg::MAX_WORKERS - 1));
    assign stat.div_last   = (cnt_reg == '0);

    assign out_chunk_start  = out_start_reg;
    assign out_chunk_end    = out_end_reg;
    assign out_victim_id    = out_victim_reg;
    assign out_grant_status = out_grant_reg;

endmodule

### hw/rtl/affinity_loop_scheduler.sv
// Affinity loop scheduler: hands out chunks of a loop iteration space to workers.
// The slave stream carries one request per beat: tuser says whether it begins a new
// partition or is a worker asking for a chunk, tdata carries the worker index.
// The master stream returns exactly one result beat per request: chunk bounds and
// the worker block that supplied it in tdata, the grant status in tuser.
// The config channel writes the worker count (index 0) and the iteration count
// (index 1); write it only while no request is in flight.
// One request is processed at a time. A bad worker id goes straight to the result;
// a local grant runs the serial divider first, an all-done answer a 16-entry scan of
// the block table, a steal that scan and then the divider, and a begin the divider
// and then a 16-entry write sweep. The next request is taken once the result is
// registered. The 17-step serial divider works out the chunk or block size, and
// the block table is single-port.
// The result sits in an output register, so a stalled receiver only holds the
// scheduler once the next result is ready to be loaded; tready of the slave side
// rises again as soon as the current result is registered.
// Reset empties every block, restores 4 workers and 1024 iterations, and leaves
// both streams idle; there is no clearing pass.
module affinity_loop_scheduler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [als_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [als_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Request stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [als_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // worker_id[3:0], zero pad
    input  logic                                 s_axis_tuser,  // req_type
    // Result stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [als_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // chunk_start[15:0],
                                                                // chunk_end[31:16],
                                                                // victim_id[35:32], zero pad
    output logic [als_pkg::GRANT_W-1:0]          m_axis_tuser   // grant_status
);

    als_pkg::cmd_t  cmd;
    als_pkg::stat_t stat;

    logic [als_pkg::INDEX_BITS-1:0] chunk_start;
    logic [als_pkg::INDEX_BITS-1:0] chunk_end;
    logic [als_pkg::GRANT_W-1:0]    grant_status;
    logic [als_pkg::WID_W-1:0]      victim_id;

    // Registers take a write in any cycle.
    assign cfg_ready = 1'b1;

    als_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    als_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_req_type      (s_axis_tuser),
        .in_worker_id     (s_axis_tdata[als_pkg::WID_W-1:0]),
        .cmd              (cmd),
        .stat             (stat),
        .out_chunk_start  (chunk_start),
        .out_chunk_end    (chunk_end),
        .out_grant_status (grant_status),
        .out_victim_id    (victim_id)
    );

    assign m_axis_tdata = {4'b0000, victim_id, chunk_end, chunk_start};
    assign m_axis_tuser = grant_status;

    // A granted chunk is never empty and never wraps past its block end.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == als_pkg::GRANT_LOCAL) ||
                          (m_axis_tuser == als_pkg::GRANT_STOLEN))
        |-> (chunk_end > chunk_start))
        else $error("granted chunk is empty or wrapped");

    // Results without a grant carry zero bounds and a zero victim.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == als_pkg::GRANT_DONE) ||
                          (m_axis_tuser == als_pkg::GRANT_BEGUN) ||
                          (m_axis_tuser == als_pkg::GRANT_BADID))
        |-> (m_axis_tdata == '0))
        else $error("non-grant result carries chunk data");

    // Only one request is in flight: accepting one closes the request side.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request accepted while one is in flight");

    // A result beat stays valid and unchanged while the receiver stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

endmodule

### sim/tb_affinity_loop_scheduler.sv
`default_nettype none

module tb_affinity_loop_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import als_pkg::*;

    // The request stream only carries one kind of request besides a begin.
    localparam logic REQ_CHUNK = ~REQ_BEGIN;

    // Items in the random part, and the point at which the run gives up.
    // Random gaps, random stalls and the long hold-off stay well inside this limit.
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_OFF     = 400;
    localparam int MAX_REPORTS  = 10;

    // One result beat as the scheduler should produce it.
    typedef struct packed {
        logic [INDEX_BITS-1:0] chunk_start;
        logic [INDEX_BITS-1:0] chunk_end;
        grant_t                status;
        logic [WID_W-1:0]      victim;
    } chunk_grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_NUM_WORKERS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = REQ_BEGIN;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [GRANT_W-1:0]    m_axis_tuser;

    // Mirror of the scheduler: its registers and the block table.
    logic [NW_W-1:0]       mirror_workers = NUM_WORKERS_RST;
    logic [INDEX_BITS-1:0] mirror_total = TOTAL_ITER_RST;
    logic [INDEX_BITS-1:0] part_next [MAX_WORKERS];
    logic [INDEX_BITS-1:0] part_end [MAX_WORKERS];

    // Grants predicted for accepted requests, oldest first.
    chunk_grant_t grants_due[$];

    int  fail_count = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  quiet_mode = 1'b0;

    affinity_loop_scheduler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // The worker count in use: zero behaves as one, anything above the
    // table size behaves as the table size.
    function automatic int unsigned workers_in_use();
        int unsigned n = 32'(mirror_workers);
        if (n == 0)
            n = 1;
        if (n > MAX_WORKERS)
            n = MAX_WORKERS;
        return n;
    endfunction

    // Iterations left in one block; a block whose next is not below its end is empty.
    function automatic int unsigned block_left(input int w);
        if (part_next[w] < part_end[w])
            return 32'(part_end[w] - part_next[w]);
        return 0;
    endfunction

    // Applies one request to the mirrored block table and returns the grant
    // that the scheduler must send back for it.
    function automatic chunk_grant_t schedule_request(input logic req,
                                                      input logic [WID_W-1:0] wid);
        chunk_grant_t g;
        int unsigned  nw;
        int unsigned  per;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  best;
        int unsigned  best_rem;
        int unsigned  size;
        g.chunk_start = '0;
        g.chunk_end   = '0;
        g.victim      = '0;
        g.status      = GRANT_DONE;
        nw = workers_in_use();
        if (req == REQ_BEGIN)
        begin
            // Equal blocks, rounded up; the tail blocks are clipped to the
            // end of the space and may be empty.
            per = (mirror_total + nw - 1) / nw;
            for (int w = 0; w < MAX_WORKERS; w++)
            begin
                lo = 0;
                hi = 0;
                if (w < nw)
                begin
                    lo = w * per;
                    hi = lo + per;
                    if (lo > mirror_total)
                        lo = 32'(mirror_total);
                    if (hi > mirror_total)
                        hi = 32'(mirror_total);
                end
                part_next[w] = lo[INDEX_BITS-1:0];
                part_end[w]  = hi[INDEX_BITS-1:0];
            end
            g.status = GRANT_BEGUN;
        end
        else if (wid >= nw)
        begin
            g.status = GRANT_BADID;
        end
        else
        begin
            if (block_left(int'(wid)) != 0)
            begin
                best = 32'(wid);
                g.status = GRANT_LOCAL;
            end
            else
            begin
                // Steal from the fullest block of the whole table, lowest
                // index first on a tie.
                best = 0;
                best_rem = 0;
                for (int w = 0; w < MAX_WORKERS; w++)
                begin
                    if (block_left(w) > best_rem)
                    begin
                        best_rem = block_left(w);
                        best = w;
                    end
                end
                if (best_rem != 0)
                    g.status = GRANT_STOLEN;
            end
            if (g.status != GRANT_DONE)
            begin
                size = (block_left(best) + nw - 1) / nw;
                lo = 32'(part_next[best]);
                hi = lo + size;
                part_next[best] = hi[INDEX_BITS-1:0];
                g.chunk_start = lo[INDEX_BITS-1:0];
                g.chunk_end   = hi[INDEX_BITS-1:0];
                g.victim      = best[WID_W-1:0];
            end
        end
        return g;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Every result beat is taken apart into its fields and compared with the
    // oldest grant still due. The pad bits above victim_id must stay zero.
    always @(posedge clk)
    begin : grant_check
        chunk_grant_t want;
        logic [INDEX_BITS-1:0] got_start;
        logic [INDEX_BITS-1:0] got_end;
        logic [WID_W-1:0]      got_victim;
        logic [OUT_DATA_W-1:36] got_pad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_start  = m_axis_tdata[15:0];
            got_end    = m_axis_tdata[31:16];
            got_victim = m_axis_tdata[35:32];
            got_pad    = m_axis_tdata[OUT_DATA_W-1:36];
            if (grants_due.size() == 0)
            begin
                note_failure($sformatf("result beat with none due: start %0d end %0d status %0d",
                                       got_start, got_end, m_axis_tuser));
            end
            else
            begin
                want = grants_due.pop_front();
                if (got_start !== want.chunk_start || got_end !== want.chunk_end
                    || m_axis_tuser !== want.status || got_victim !== want.victim
                    || got_pad !== '0)
                    note_failure($sformatf(
                        "expected start %0d end %0d status %0d victim %0d, got %0d %0d %0d %0d pad %h",
                        want.chunk_start, want.chunk_end, want.status, want.victim,
                        got_start, got_end, m_axis_tuser, got_victim, got_pad));
            end
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // The receiver drops tready about 8 times in a hundred, except in quiet
    // mode. A hold-off request keeps it low for a counted number of cycles.
    initial
    begin : result_sink
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= quiet_mode || ($urandom_range(99) >= 8);
            end
        end
    end

    function automatic bit sender_gap();
        return !quiet_mode && ($urandom_range(99) < 8);
    endfunction

    // Offers one request beat and returns once it has been accepted. tvalid
    // stays high afterwards so that the next call can follow back to back.
    task automatic send_req(input logic req, input logic [WID_W-1:0] wid);
        @(negedge clk);
        while (sender_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{(IN_DATA_W-WID_W){1'b0}}, wid};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        grants_due.push_back(schedule_request(req, wid));
        items_sent++;
    endtask

    // Stops offering requests and waits until every grant due has arrived.
    task automatic drain_grants();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with nothing in flight. Every request has
    // a result, so an empty list of grants due means the scheduler is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_grants();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_NUM_WORKERS)
            mirror_workers = val[NW_W-1:0];
        else
            mirror_total = val[INDEX_BITS-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset every block is empty, so worker 0 reports done; ids 4 and 15 are bad.
    // Then a begin with the reset registers: 4 workers over 1024 iterations.
    task automatic test_reset_state();
        send_req(REQ_CHUNK, 4'd0);
        send_req(REQ_CHUNK, 4'd4);
        send_req(REQ_CHUNK, 4'd15);
        send_req(REQ_BEGIN, 4'd9);
        send_req(REQ_CHUNK, 4'd0);
        send_req(REQ_CHUNK, 4'd3);
    endtask

    // Worker counts at and beyond both ends, and iteration counts of zero
    // and of the full index range.
    task automatic test_register_extremes();
        // A count of zero acts as one worker; an empty space is done at once.
        write_reg(CFG_NUM_WORKERS, 16'd0);
        write_reg(CFG_TOTAL_ITER, 16'd0);
        send_req(REQ_BEGIN, 4'd0);
        send_req(REQ_CHUNK, 4'd0);
        send_req(REQ_CHUNK, 4'd1);
        // The largest field value acts as the table size, with upper data bits set.
        write_reg(CFG_NUM_WORKERS, 16'hFFFF);
        write_reg(CFG_TOTAL_ITER, 16'hFFFF);
        send_req(REQ_BEGIN, 4'd15);
        send_req(REQ_CHUNK, 4'd15);
        send_req(REQ_CHUNK, 4'd0);
        // Lowering the count after a begin changes the divisor and the id
        // check at once, but not the partition.
        write_reg(CFG_NUM_WORKERS, 16'd2);
        send_req(REQ_CHUNK, 4'd1);
        send_req(REQ_CHUNK, 4'd2);
    endtask

    // Stealing: ties go to the lowest index, and blocks of workers that are
    // no longer counted are still reached by the scan.
    task automatic test_stealing();
        write_reg(CFG_NUM_WORKERS, 16'd3);
        write_reg(CFG_TOTAL_ITER, 16'd10);
        send_req(REQ_BEGIN, 4'd0);
        send_req(REQ_CHUNK, 4'd2);
        send_req(REQ_CHUNK, 4'd2);
        send_req(REQ_CHUNK, 4'd2);
        write_reg(CFG_NUM_WORKERS, 16'd4);
        write_reg(CFG_TOTAL_ITER, 16'd8);
        send_req(REQ_BEGIN, 4'd0);
        write_reg(CFG_NUM_WORKERS, 16'd1);
        for (int k = 0; k < 5; k++)
            send_req(REQ_CHUNK, 4'd0);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the output register fills and the scheduler stops taking requests.
    task automatic test_backpressure();
        write_reg(CFG_NUM_WORKERS, 16'd4);
        write_reg(CFG_TOTAL_ITER, 16'd4096);
        send_req(REQ_BEGIN, 4'd0);
        hold_left = HOLD_OFF;
        for (int k = 0; k < 12; k++)
            send_req(REQ_CHUNK, 4'($urandom_range(3)));
        drain_grants();
    endtask

    // Random phases: new registers, a begin, then a run of requests that are
    // mostly from workers in range, with stray ids and stray begins mixed in.
    // Small spaces and small worker counts dominate so that most phases
    // drain to done.
    task automatic test_random_phases();
        int          done_items;
        int unsigned pick;
        int unsigned run_len;
        logic [CFG_DATA_W-1:0] val;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                val = 16'($urandom_range(1, 6));
                if ($urandom_range(3) == 0)
                    val[CFG_DATA_W-1:NW_W] = (CFG_DATA_W-NW_W)'($urandom);
                write_reg(CFG_NUM_WORKERS, val);
            end
            else if (pick < 85)
            begin
                write_reg(CFG_NUM_WORKERS, 16'($urandom_range(7, 16)));
            end
            else
            begin
                write_reg(CFG_NUM_WORKERS, 16'($urandom_range(0, 31)));
            end
            pick = $urandom_range(99);
            if (pick < 60)
                val = 16'($urandom_range(0, 64));
            else if (pick < 85)
                val = 16'($urandom_range(65, 2000));
            else if (pick < 92)
                val = 16'hFFFF;
            else
                val = 16'($urandom);
            write_reg(CFG_TOTAL_ITER, val);
            // Now and then the new registers are left waiting for a later begin.
            if ($urandom_range(9) != 0)
            begin
                send_req(REQ_BEGIN, 4'($urandom));
                done_items++;
            end
            run_len = $urandom_range(8, 80);
            for (int k = 0; k < run_len && done_items < RANDOM_ITEMS; k++)
            begin
                // A stretch of the run goes without any idling on either side.
                quiet_mode = (done_items >= 300 && done_items < 450);
                pick = $urandom_range(99);
                if (pick < 90)
                    send_req(REQ_CHUNK, 4'($urandom_range(workers_in_use() - 1)));
                else if (pick < 96)
                    send_req(REQ_CHUNK, 4'($urandom));
                else
                    send_req(REQ_BEGIN, 4'($urandom));
                done_items++;
            end
            quiet_mode = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_affinity_loop_scheduler: FAIL");
        $finish;
    end

    initial
    begin : run_tests
        for (int w = 0; w < MAX_WORKERS; w++)
        begin
            part_next[w] = '0;
            part_end[w]  = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_register_extremes();
        test_stealing();
        test_backpressure();
        test_random_phases();

        // Let any late or extra beat show up before judging.
        drain_grants();
        repeat (100) @(posedge clk);
        if (grants_due.size() != 0)
            note_failure($sformatf("%0d results never arrived", grants_due.size()));
        if (fail_count == 0)
            $display("tb_affinity_loop_scheduler: PASS");
        else
            $display("tb_affinity_loop_scheduler: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
